[rtl/ltlp_pkg.sv]
// Shared types, constants and the month-length table for the log line parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package ltlp_pkg;

    localparam logic [6:0] MaxMessage = 7'd100;

    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChColon = 8'h3A;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChCr    = 8'h0D;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FORMAT = 2'd1,
        ST_DATE   = 2'd2,
        ST_TIME   = 2'd3
    } status_t;

    // Everything captured from one finished line.
    typedef struct packed {
        logic       bad;
        logic [6:0] day;
        logic [6:0] month;
        logic [6:0] century;
        logic [6:0] year_low;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
        logic [6:0] msg_len;
    } line_t;

    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] d;
        case (month)
            4'd2:    d = 5'd28;
            4'd4:    d = 5'd30;
            4'd6:    d = 5'd30;
            4'd9:    d = 5'd30;
            4'd11:   d = 5'd30;
            default: d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/log_timestamp_line_parser_core.sv]
// Top level of the log line timestamp parser: byte parser followed by the check stage.
// Depends on ltlp_pkg, ltlp_parse and ltlp_check.
//
// Channel  Dir  Word
// s_       in   tdata[7:0] byte of the line, tlast marks the final byte
// m_       out  tdata: day, month, year, hour, minute, second, length; tuser: status
//
// One byte is taken every cycle while s_tready is high; the result of a line passes the
// line register and then the output register.
// Reset clears the parser and the valid flags of the line and output registers.
// A stalled result blocks input only once the line register also holds a finished line.
`default_nettype none

module log_timestamp_line_parser_core
    import ltlp_pkg::*;
#(
    parameter logic [6:0] MaxMessageLen = MaxMessage
)
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // char_code
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // day, month, year, hour, minute, second, message_length
    output logic [1:0]       m_tuser    // status
);

    logic  line_valid;
    logic  line_ready;
    line_t line;

    ltlp_parse #(
        .MaxMessageLen (MaxMessageLen)
    ) u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .line_valid (line_valid),
        .line       (line),
        .line_ready (line_ready)
    );

    ltlp_check u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_valid (line_valid),
        .line       (line),
        .line_ready (line_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

[rtl/ltlp_parse.sv]
// Byte-wide phase machine and digit accumulators for one log line.
// Depends on ltlp_pkg; hands each finished line to ltlp_check through a one-entry register.
`default_nettype none

module ltlp_parse
    import ltlp_pkg::*;
#(
    parameter logic [6:0] MaxMessageLen = MaxMessage
)
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    output logic            line_valid,
    output line_t           line,
    input  wire logic       line_ready
);

    typedef enum logic [3:0] {
        PH_DAY     = 4'd0,
        PH_MONTH   = 4'd1,
        PH_YEAR    = 4'd2,
        PH_HOUR    = 4'd3,
        PH_MINUTE  = 4'd4,
        PH_SECOND  = 4'd5,
        PH_SPACE2  = 4'd6,
        PH_MESSAGE = 4'd7
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [2:0] count_reg, count_next;
    logic [6:0] day_reg, day_next;
    logic [6:0] month_reg, month_next;
    logic [6:0] century_reg, century_next;
    logic [6:0] year_low_reg, year_low_next;
    logic [6:0] hour_reg, hour_next;
    logic [6:0] minute_reg, minute_next;
    logic [6:0] second_reg, second_next;
    logic [6:0] msg_reg, msg_next;
    logic       err_reg, err_next;
    logic       line_valid_reg, line_valid_next;
    line_t      line_reg, line_snap;

    logic       accept;
    logic       is_digit;
    logic [3:0] digit;
    logic [6:0] field_acc;
    logic [6:0] field_shifted;
    logic [2:0] min_digits;
    logic [2:0] max_digits;
    logic [7:0] sep;

    function automatic logic [6:0] shift_in(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] t;
        t = {4'b0, acc} * 11'd10 + {7'b0, d};
        return t[6:0];
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !line_valid_reg || line_ready;
    assign is_digit = s_tdata inside {[8'h30:8'h39]};
    assign digit    = s_tdata[3:0];

    always_comb begin
        case (phase_reg)
            PH_DAY: begin
                field_acc = day_reg; min_digits = 3'd1; max_digits = 3'd2; sep = ChSlash;
            end
            PH_MONTH: begin
                field_acc = month_reg; min_digits = 3'd1; max_digits = 3'd2; sep = ChSlash;
            end
            PH_HOUR: begin
                field_acc = hour_reg; min_digits = 3'd1; max_digits = 3'd2; sep = ChColon;
            end
            PH_MINUTE: begin
                field_acc = minute_reg; min_digits = 3'd2; max_digits = 3'd2; sep = ChColon;
            end
            PH_SECOND: begin
                field_acc = second_reg; min_digits = 3'd2; max_digits = 3'd2; sep = ChSpace;
            end
            default: begin
                field_acc = century_reg; min_digits = 3'd4; max_digits = 3'd4; sep = ChSpace;
            end
        endcase
    end

    assign field_shifted = shift_in(field_acc, digit);

    always_comb begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        day_next      = day_reg;
        month_next    = month_reg;
        century_next  = century_reg;
        year_low_next = year_low_reg;
        hour_next     = hour_reg;
        minute_next   = minute_reg;
        second_next   = second_reg;
        msg_next      = msg_reg;
        err_next      = err_reg;
        if (!err_reg) begin
            case (phase_reg)
                PH_DAY, PH_MONTH, PH_HOUR, PH_MINUTE, PH_SECOND: begin
                    if (is_digit && count_reg < max_digits) begin
                        count_next = count_reg + 3'd1;
                        case (phase_reg)
                            PH_DAY:    day_next    = field_shifted;
                            PH_MONTH:  month_next  = field_shifted;
                            PH_HOUR:   hour_next   = field_shifted;
                            PH_MINUTE: minute_next = field_shifted;
                            default:   second_next = field_shifted;
                        endcase
                    end else if (s_tdata == sep && count_reg >= min_digits) begin
                        phase_next = phase_t'(phase_reg + 4'd1);
                        count_next = 3'd0;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_YEAR: begin
                    if (is_digit && count_reg < 3'd4) begin
                        count_next = count_reg + 3'd1;
                        if (count_reg < 3'd2) begin
                            century_next = shift_in(century_reg, digit);
                        end else begin
                            year_low_next = shift_in(year_low_reg, digit);
                        end
                    end else if (s_tdata == ChSpace && count_reg == 3'd4) begin
                        phase_next = PH_HOUR;
                        count_next = 3'd0;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_SPACE2: begin
                    if (s_tdata == ChSpace) begin
                        phase_next = PH_MESSAGE;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                PH_MESSAGE: begin
                    if (s_tdata != ChLf && s_tdata != ChCr && msg_reg < MaxMessageLen) begin
                        msg_next = msg_reg + 7'd1;
                    end else begin
                        err_next = 1'b1;
                    end
                end
                default: err_next = 1'b1;
            endcase
        end
    end

    always_comb begin
        line_snap.bad      = err_next || phase_next != PH_MESSAGE || msg_next == 7'd0;
        line_snap.day      = day_next;
        line_snap.month    = month_next;
        line_snap.century  = century_next;
        line_snap.year_low = year_low_next;
        line_snap.hour     = hour_next;
        line_snap.minute   = minute_next;
        line_snap.second   = second_next;
        line_snap.msg_len  = msg_next;
    end

    always_comb begin
        line_valid_next = line_valid_reg;
        if (accept && s_tlast) begin
            line_valid_next = 1'b1;
        end else if (line_ready) begin
            line_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_DAY;
            count_reg      <= 3'd0;
            day_reg        <= 7'd0;
            month_reg      <= 7'd0;
            century_reg    <= 7'd0;
            year_low_reg   <= 7'd0;
            hour_reg       <= 7'd0;
            minute_reg     <= 7'd0;
            second_reg     <= 7'd0;
            msg_reg        <= 7'd0;
            err_reg        <= 1'b0;
            line_valid_reg <= 1'b0;
        end else begin
            line_valid_reg <= line_valid_next;
            if (accept) begin
                if (s_tlast) begin
                    phase_reg    <= PH_DAY;
                    count_reg    <= 3'd0;
                    day_reg      <= 7'd0;
                    month_reg    <= 7'd0;
                    century_reg  <= 7'd0;
                    year_low_reg <= 7'd0;
                    hour_reg     <= 7'd0;
                    minute_reg   <= 7'd0;
                    second_reg   <= 7'd0;
                    msg_reg      <= 7'd0;
                    err_reg      <= 1'b0;
                end else begin
                    phase_reg    <= phase_next;
                    count_reg    <= count_next;
                    day_reg      <= day_next;
                    month_reg    <= month_next;
                    century_reg  <= century_next;
                    year_low_reg <= year_low_next;
                    hour_reg     <= hour_next;
                    minute_reg   <= minute_next;
                    second_reg   <= second_next;
                    msg_reg      <= msg_next;
                    err_reg      <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            line_reg <= line_snap;
        end
    end

    assign line_valid = line_valid_reg;
    assign line       = line_reg;

endmodule

`default_nettype wire

[rtl/ltlp_check.sv]
// Date and time range checks on a finished line, and the result output register.
// Depends on ltlp_pkg; fed by ltlp_parse.
`default_nettype none

module ltlp_check
    import ltlp_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        line_valid,
    input  wire line_t       line,
    output logic             line_ready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,
    output logic [1:0]       m_tuser
);

    logic        m_tvalid_reg, m_tvalid_next;
    logic [55:0] m_tdata_reg, m_tdata_next;
    status_t     status_reg, status_next;

    logic [13:0] year;
    logic        leap;
    logic [4:0]  dim;
    logic        month_ok;
    logic        day_ok;
    logic        time_ok;
    logic        load;

    assign line_ready = !m_tvalid_reg || m_tready;
    assign load       = line_valid && line_ready;

    assign year     = 14'(line.century) * 14'd100 + 14'(line.year_low);
    assign leap     = (line.year_low != 7'd0) ? (line.year_low[1:0] == 2'b00)
                                              : (line.century[1:0] == 2'b00);
    assign month_ok = line.month inside {[7'd1:7'd12]};
    assign dim      = (line.month == 7'd2 && leap) ? 5'd29 : month_days(line.month[3:0]);
    assign day_ok   = line.day != 7'd0 && line.day <= 7'(dim);
    assign time_ok  = line.hour <= 7'd23 && line.minute <= 7'd59 && line.second <= 7'd59;

    always_comb begin
        if (line.bad) begin
            status_next  = ST_FORMAT;
            m_tdata_next = 56'd0;
        end else begin
            if (!month_ok || !day_ok) begin
                status_next = ST_DATE;
            end else if (!time_ok) begin
                status_next = ST_TIME;
            end else begin
                status_next = ST_OK;
            end
            m_tdata_next = {line.msg_len, line.second, line.minute, line.hour,
                            year, line.month, line.day};
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= m_tdata_next;
            status_reg  <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire
